// ===== sv/binomial_coefficient_unit_defines.svh =====
// Assertion helpers for the checker file bcu_checker.sv.
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH

// Checked only outside reset.
`define BCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bcu_pkg.sv =====
package bcu_pkg;

  localparam int unsigned RESULT_BITS_DEF = 63;
  localparam int unsigned IN_W            = 32;
  // n after the validity check is nonnegative and fits 31 bits
  localparam int unsigned N_W             = 31;
  localparam int unsigned MUL_W           = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD,
    S_CHECK,
    S_DIV,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic mul_lo;
    logic mul_hi;
    logic add;
    logic check;
    logic div_step;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic pre_done;   // invalid or trivial pair, answer known
    logic ovf;        // next coefficient does not fit
    logic div_last;   // last quotient bit this cycle
    logic step_last;  // current step is the final one
  } stat_t;

endpackage

// ===== sv/bcu_if.sv =====
interface bcu_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bcu_pkg::IN_W-1:0]   n;
  logic signed [bcu_pkg::IN_W-1:0]   k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bcu_out_if #(
  parameter int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [RESULT_BITS-1:0] value;
  logic                   overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

// ===== sv/bcu_ctrl.sv =====
module bcu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  bcu_pkg::stat_t  stat,
  output bcu_pkg::ctrl_t  ctrl
);

  bcu_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcu_pkg::S_IDLE:   if (in_valid) state_nxt = bcu_pkg::S_PREP;
      bcu_pkg::S_PREP:   state_nxt = stat.pre_done ? bcu_pkg::S_WRITE : bcu_pkg::S_MUL_LO;
      bcu_pkg::S_MUL_LO: state_nxt = bcu_pkg::S_MUL_HI;
      bcu_pkg::S_MUL_HI: state_nxt = bcu_pkg::S_ADD;
      bcu_pkg::S_ADD:    state_nxt = bcu_pkg::S_CHECK;
      bcu_pkg::S_CHECK:  state_nxt = stat.ovf ? bcu_pkg::S_WRITE : bcu_pkg::S_DIV;
      bcu_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_nxt = stat.step_last ? bcu_pkg::S_WRITE : bcu_pkg::S_MUL_LO;
        end
      end
      bcu_pkg::S_WRITE:  if (slot_free) state_nxt = bcu_pkg::S_IDLE;
      default:           state_nxt = bcu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.load_in  = (state_r == bcu_pkg::S_IDLE) && in_valid;
    ctrl.prep     = (state_r == bcu_pkg::S_PREP);
    ctrl.mul_lo   = (state_r == bcu_pkg::S_MUL_LO);
    ctrl.mul_hi   = (state_r == bcu_pkg::S_MUL_HI);
    ctrl.add      = (state_r == bcu_pkg::S_ADD);
    ctrl.check    = (state_r == bcu_pkg::S_CHECK);
    ctrl.div_step = (state_r == bcu_pkg::S_DIV);
    ctrl.out_load = (state_r == bcu_pkg::S_WRITE) && slot_free;
    in_ready      = (state_r == bcu_pkg::S_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/bcu_datapath.sv =====
module bcu_datapath #(
  parameter int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [bcu_pkg::IN_W-1:0] in_n,
  input  logic signed [bcu_pkg::IN_W-1:0] in_k,
  input  bcu_pkg::ctrl_t                ctrl,
  output bcu_pkg::stat_t                stat,
  output logic [RESULT_BITS-1:0]        out_value,
  output logic                          out_overflow
);

  localparam int unsigned RB   = RESULT_BITS;
  localparam int unsigned NW   = bcu_pkg::N_W;
  localparam int unsigned MW   = bcu_pkg::MUL_W;
  localparam int unsigned PW   = RB + NW;          // product r * (n - i)
  localparam int unsigned CW   = $clog2(RB);
  localparam int unsigned IW   = bcu_pkg::IN_W;

  logic signed [IW-1:0]  nin_r, kin_r;
  logic [NW-1:0]         n_r, k_r, i_r;
  logic [RB-1:0]         r_r;
  logic [2*MW-1:0]       mul_r;
  logic [PW-1:0]         prod_r;
  logic [NW-1:0]         rem_r;
  logic [RB-1:0]         q_r;
  logic [CW-1:0]         cnt_r;
  logic [RB-1:0]         res_val_r, val_r;
  logic                  res_ovf_r, ovf_r;

  // symmetry rule on 33-bit signed values so n - k never wraps
  logic signed [IW:0]    n_x, k_x, nk, kred;
  logic                  invalid, trivial;

  logic [NW-1:0]         num, den;
  logic [2*MW-1:0]       r64;
  logic [MW-1:0]         mul_a, mul_b;
  logic [2*MW-1:0]       mul_p;
  logic [3*MW-1:0]       sum;
  logic [NW:0]           trial;
  logic                  qbit;
  logic [NW-1:0]         rem_nxt;
  logic [RB-1:0]         q_nxt;

  always_comb begin
    n_x     = {nin_r[IW-1], nin_r};
    k_x     = {kin_r[IW-1], kin_r};
    nk      = n_x - k_x;
    kred    = (k_x > nk) ? nk : k_x;
    invalid = nin_r[IW-1] | kred[IW];
    trivial = (kred == '0);
  end

  // shared 32x32 multiplier: low then high half of r times (n - i)
  always_comb begin
    num   = n_r - i_r;
    den   = i_r + NW'(1);
    r64   = (2*MW)'(r_r);
    mul_a = ctrl.mul_lo ? r64[MW-1:0] : r64[2*MW-1:MW];
    mul_b = MW'(num);
    mul_p = mul_a * mul_b;
    sum   = (3*MW)'(prod_r) + ({{MW{1'b0}}, mul_r} << MW);
  end

  // restoring divide, one quotient bit per cycle; remainder stays below den
  always_comb begin
    trial   = {rem_r, q_r[RB-1]} - {1'b0, den};
    qbit    = !trial[NW];
    rem_nxt = qbit ? trial[NW-1:0] : {rem_r[NW-2:0], q_r[RB-1]};
    q_nxt   = {q_r[RB-2:0], qbit};
  end

  always_comb begin
    stat           = '0;
    stat.pre_done  = invalid | trivial;
    // exact quotient exceeds the limit iff prod >= den << RB
    stat.ovf       = (prod_r[PW-1:RB] >= den);
    stat.div_last  = (cnt_r == CW'(RB - 1));
    stat.step_last = (den == k_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      nin_r <= in_n;
      kin_r <= in_k;
    end
    if (ctrl.prep) begin
      n_r       <= nin_r[NW-1:0];
      k_r       <= kred[NW-1:0];
      i_r       <= '0;
      r_r       <= RB'(1);
      res_val_r <= invalid ? '0 : RB'(1);
      res_ovf_r <= 1'b0;
    end
    if (ctrl.mul_lo || ctrl.mul_hi) begin
      mul_r <= mul_p;
    end
    if (ctrl.mul_hi) begin
      prod_r <= PW'(mul_r);
    end
    if (ctrl.add) begin
      prod_r <= sum[PW-1:0];
    end
    if (ctrl.check) begin
      rem_r <= prod_r[PW-1:RB];
      q_r   <= prod_r[RB-1:0];
      cnt_r <= '0;
      if (stat.ovf) begin
        res_val_r <= '0;
        res_ovf_r <= 1'b1;
      end
    end
    if (ctrl.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + CW'(1);
      if (stat.div_last) begin
        r_r       <= q_nxt;
        i_r       <= den;
        res_val_r <= q_nxt;
        res_ovf_r <= 1'b0;
      end
    end
    if (ctrl.out_load) begin
      val_r <= res_val_r;
      ovf_r <= res_ovf_r;
    end
  end

  assign out_value    = val_r;
  assign out_overflow = ovf_r;

endmodule

// ===== sv/binomial_coefficient_unit.sv =====
// Channel   Dir  Payload                          Handshake
// in_ch     in   n[31:0] s, k[31:0] s             valid/ready
// out_ch    out  value[RESULT_BITS-1:0], overflow valid/ready
//
// One item at a time: accept, a setup state, then per running-product step
// a low and a high multiply, an add, an overflow check and a divide for
// RESULT_BITS quotient bits, then the output register once it is free.
// Steps = reduced k, or fewer on overflow.
// The divider's one-bit-per-cycle loop sets the step time.
// rst_n is synchronous; the result register holds until out_ch.ready.
module binomial_coefficient_unit #(
  parameter int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bcu_in_if.sink       in_ch,
  bcu_out_if.source    out_ch
);

  bcu_pkg::ctrl_t ctrl;
  bcu_pkg::stat_t stat;

  bcu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  bcu_datapath #(
    .RESULT_BITS (RESULT_BITS)
  ) u_dp (
    .clk          (clk),
    .in_n         (in_ch.n),
    .in_k         (in_ch.k),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_value    (out_ch.value),
    .out_overflow (out_ch.overflow)
  );

endmodule

// ===== sv/bcu_checker.sv =====
`include "binomial_coefficient_unit_defines.svh"

module bcu_checker #(
  parameter int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [RESULT_BITS-1:0] out_value,
  input logic                   overflow
);

  // a result held back must stay offered
  `BCU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // overflow always comes with a zero value
  `BCU_ASSERT(a_ovf_zero, out_valid && overflow |-> out_value == '0, "overflow with nonzero value")

  // busy right after taking a request
  `BCU_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "ready again right after accept")

  // reset empties the result register
  `BCU_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind binomial_coefficient_unit bcu_checker #(
  .RESULT_BITS (RESULT_BITS)
) u_bcu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value),
  .overflow  (out_ch.overflow)
);

// ===== verif/bcu_result_checker.sv =====
`timescale 1ns / 100ps
module bcu_result_checker #(
  parameter int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [bcu_pkg::IN_W-1:0] in_n,
  input  logic signed [bcu_pkg::IN_W-1:0] in_k,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [RESULT_BITS-1:0]          out_value,
  input  logic                            out_overflow,
  output int                              fail_count,
  output int                              open_requests
);

  typedef struct {
    logic signed [bcu_pkg::IN_W-1:0] n;
    logic signed [bcu_pkg::IN_W-1:0] k;
    logic [RESULT_BITS-1:0]          value;
    logic                            overflow;
  } coeff_rec_t;

  coeff_rec_t pending_coeffs[$];

  // Exact running product C(n,i+1) = C(n,i) * (n-i) / (i+1), reduced by the
  // gcd first so the product never leaves 64 bits before the range test.
  function automatic void predict_binomial(
    input  logic signed [bcu_pkg::IN_W-1:0] n_in,
    input  logic signed [bcu_pkg::IN_W-1:0] k_in,
    output logic [RESULT_BITS-1:0]          coeff,
    output logic                            too_big
  );
    longint          set_size;
    longint          choose;
    longint unsigned prod;
    longint unsigned cap;
    longint unsigned idx;
    longint unsigned num;
    longint unsigned den;
    longint unsigned ga;
    longint unsigned gb;
    longint unsigned gt;
    longint unsigned prod_red;
    longint unsigned den_red;
    longint unsigned factor;
    set_size = n_in;
    choose   = k_in;
    coeff    = '0;
    too_big  = 1'b0;
    if (choose > set_size - choose) begin
      choose = set_size - choose;
    end
    if (set_size < 0 || choose < 0 || choose > set_size) begin
      return;
    end
    if (choose == 0 || choose == set_size) begin
      coeff = RESULT_BITS'(1);
      return;
    end
    cap  = (64'd1 << RESULT_BITS) - 64'd1;
    prod = 64'd1;
    for (idx = 0; idx < longint'(unsigned'(choose)); idx++) begin
      num = longint'(unsigned'(set_size)) - idx;
      den = idx + 64'd1;
      ga  = prod;
      gb  = den;
      while (gb != 0) begin
        gt = ga % gb;
        ga = gb;
        gb = gt;
      end
      prod_red = prod / ga;
      den_red  = den / ga;
      factor   = num / den_red;
      if (factor != 0 && prod_red > cap / factor) begin
        too_big = 1'b1;
        return;
      end
      prod = prod_red * factor;
    end
    coeff = prod[RESULT_BITS-1:0];
  endfunction

  always @(posedge clk) begin : watch
    coeff_rec_t head;
    coeff_rec_t fresh;
    int         errs;
    if (!rst_n) begin
      fail_count    <= 0;
      open_requests <= 0;
    end else begin
      errs = 0;
      // retire first: a result can never belong to a request taken this edge
      if (out_valid && out_ready) begin
        if (pending_coeffs.size() == 0) begin
          $display("%0t: result with no request open, value=%0d overflow=%0b",
                   $time, out_value, out_overflow);
          errs++;
        end else begin
          head = pending_coeffs.pop_front();
          if (out_value !== head.value) begin
            $display("%0t: C(%0d,%0d) value expected %0d actual %0d",
                     $time, head.n, head.k, head.value, out_value);
            errs++;
          end
          if (out_overflow !== head.overflow) begin
            $display("%0t: C(%0d,%0d) overflow expected %0b actual %0b",
                     $time, head.n, head.k, head.overflow, out_overflow);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        fresh.n = in_n;
        fresh.k = in_k;
        predict_binomial(in_n, in_k, fresh.value, fresh.overflow);
        pending_coeffs.push_back(fresh);
      end
      fail_count    <= fail_count + errs;
      open_requests <= pending_coeffs.size();
    end
  end

endmodule

// ===== verif/tb_binomial_coefficient_unit.sv =====
`timescale 1ns / 100ps
module tb_binomial_coefficient_unit;

  localparam int unsigned RESULT_BITS = bcu_pkg::RESULT_BITS_DEF;
  // cycle limit for the whole run
  localparam int unsigned RUN_LIMIT   = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 2400;
  localparam int unsigned PHASE_ITEMS = 62;

  localparam logic signed [bcu_pkg::IN_W-1:0] N_MAX = 32'sh7fff_ffff;
  localparam logic signed [bcu_pkg::IN_W-1:0] N_MIN = 32'sh8000_0000;

  logic        clk;
  logic        rst_n;
  int          sender_idle_pct;
  int          recv_stall_pct;
  int          fail_count;
  int          open_requests;
  int unsigned cycle_count;

  bcu_in_if                              in_ch ();
  bcu_out_if #(.RESULT_BITS(RESULT_BITS)) out_ch ();

  binomial_coefficient_unit #(.RESULT_BITS(RESULT_BITS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bcu_result_checker #(.RESULT_BITS(RESULT_BITS)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_n          (in_ch.n),
    .in_k          (in_ch.k),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_value     (out_ch.value),
    .out_overflow  (out_ch.overflow),
    .fail_count    (fail_count),
    .open_requests (open_requests)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("binomial_coefficient_unit: mismatch");
    $finish;
  end

  // valid is only lowered when an idle cycle follows, so it never toggles
  // twice in one step
  task automatic send_request(input logic signed [bcu_pkg::IN_W-1:0] n_val,
                              input logic signed [bcu_pkg::IN_W-1:0] k_val);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.n     <= n_val;
    in_ch.k     <= k_val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_requests != 0) @(posedge clk);
  endtask

  // mostly pairs that reach the iteration, kept small so runs stay short
  task automatic random_pair(output logic signed [bcu_pkg::IN_W-1:0] n_val,
                             output logic signed [bcu_pkg::IN_W-1:0] k_val);
    int unsigned sel;
    int unsigned base;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      n_val = $urandom;
      k_val = $urandom;
    end else if (sel < 65) begin
      base  = $urandom_range(0, 70);
      n_val = base;
      k_val = $urandom_range(0, base);
    end else if (sel < 85) begin
      n_val = $urandom_range(0, 32'h7fff_ffff);
      k_val = $urandom_range(0, 4);
    end else begin
      base  = $urandom_range(1, 32'h7fff_ffff);
      n_val = base;
      k_val = base - $urandom_range(0, 4);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    logic signed [bcu_pkg::IN_W-1:0] n_val;
    logic signed [bcu_pkg::IN_W-1:0] k_val;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    repeat (count) begin
      random_pair(n_val, k_val);
      send_request(n_val, k_val);
    end
    // hold off until every open request is answered
    drain_requests();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.n         <= '0;
    in_ch.k         <= '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // trivial pairs, and N_MAX choose N_MAX - 1, which reduces to k = 1
    send_request(0, 0);
    send_request(5, 5);
    send_request(5, 0);
    send_request(1, 1);
    send_request(N_MAX, N_MAX);
    send_request(N_MAX, N_MAX - 1);
    // invalid pairs
    send_request(-1, 0);
    send_request(5, -1);
    send_request(5, 6);
    send_request(0, 1);
    send_request(0, -1);
    send_request(-5, -3);
    send_request(N_MIN, N_MIN);
    send_request(N_MAX, N_MIN);
    send_request(N_MIN, N_MAX);
    // iteration, symmetry, fit and overflow edges
    send_request(2, 1);
    send_request(10, 3);
    send_request(10, 7);
    send_request(N_MAX, 1);
    send_request(N_MAX, 2);
    send_request(N_MAX, 3);
    send_request(N_MAX, 32'sh4000_0000);
    send_request(66, 33);
    send_request(67, 33);
    send_request(68, 34);
    drain_requests();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(72, 0, PHASE_ITEMS);
    run_phase(0, 72, PHASE_ITEMS);
    run_phase(12, 12, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && open_requests == 0) begin
      $display("binomial_coefficient_unit: match");
    end else begin
      $display("binomial_coefficient_unit: mismatch");
    end
    $finish;
  end

endmodule
